[hw/rtl/ols_pkg.sv]
// ols_pkg: shared constants, operation codes and control structs for the
// ordered list store. No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ols_pkg;

    // Store depth (entries). COUNT_W must hold CAPACITY itself.
    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Max tree: leaves padded up to a power of two, one level per cycle
    localparam int LEVELS   = $clog2(CAPACITY);
    localparam int LEAVES   = 1 << LEVELS;
    localparam int LVL_W    = $clog2(LEVELS + 1);

    // Packed stream widths
    localparam int S_DATA_W = ((VAL_W + POS_W + 7) / 8) * 8;
    localparam int S_USER_W = OP_W;
    localparam int M_DATA_W = ((COUNT_W + VAL_W + 7) / 8) * 8;
    localparam int M_USER_W = 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_FRONT  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_VAL = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE_POS = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;  // capture the accepted item
        logic decide;     // resolve target index and outcome
        logic execute;    // shift cells, update the count
        logic load_out;   // capture the result item
    } dp_cmd_t;

endpackage

[hw/rtl/ols_datapath.sv]
// ols_datapath: entry cells with shift insert/remove, match search,
// registered max tree and the result register. Depends on ols_pkg.
`timescale 1ns / 1ps

module ols_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ols_pkg::dp_cmd_t               cmd,
    input  logic [ols_pkg::OP_W-1:0]       op_in,
    input  logic [ols_pkg::VAL_W-1:0]      value_in,
    input  logic [ols_pkg::POS_W-1:0]      position_in,
    output logic                           ok_out,
    output logic [ols_pkg::COUNT_W-1:0]    count_out,
    output logic [ols_pkg::VAL_W-1:0]      largest_out
);

    localparam int CAP = ols_pkg::CAPACITY;
    localparam int LVS = ols_pkg::LEAVES;

    // Captured item
    logic [ols_pkg::OP_W-1:0]    op_reg;
    logic [ols_pkg::VAL_W-1:0]   value_reg;
    logic [ols_pkg::POS_W-1:0]   pos_reg;

    // Store state
    logic [ols_pkg::VAL_W-1:0]   cell_reg  [CAP];
    logic [ols_pkg::VAL_W-1:0]   cell_next [CAP];
    logic [ols_pkg::COUNT_W-1:0] count_reg, count_next;

    // Decision registers
    logic                        ins_reg, ins_next;
    logic                        del_reg, del_next;
    logic                        ok_reg, ok_next;
    logic [ols_pkg::IDX_W-1:0]   idx_reg, idx_next;

    // Match search
    logic [CAP-1:0]              match;
    logic                        found;
    logic [ols_pkg::IDX_W-1:0]   found_idx;
    logic                        full;
    logic [ols_pkg::COUNT_W-1:0] ins_pos;

    // Max tree: heap order, nodes 1..LVS-1 registered, leaves LVS..2*LVS-1
    logic [ols_pkg::VAL_W-1:0]   tval [2*LVS];
    logic                        tvld [2*LVS];
    logic [ols_pkg::VAL_W-1:0]   node_val_reg [1:LVS-1];
    logic                        node_vld_reg [1:LVS-1];

    // Result register
    logic                        ok_out_reg;
    logic [ols_pkg::COUNT_W-1:0] count_out_reg;
    logic [ols_pkg::VAL_W-1:0]   largest_out_reg;

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= op_in;
            value_reg <= value_in;
            pos_reg   <= position_in;
        end
    end

    // Equality against every live cell, first hit wins
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = 0; i < CAP; i++) begin
            match[i] = (ols_pkg::COUNT_W'(i) < count_reg) && (cell_reg[i] == value_reg);
        end
        for (int i = CAP - 1; i >= 0; i--) begin
            if (match[i]) begin
                found     = 1'b1;
                found_idx = ols_pkg::IDX_W'(i);
            end
        end
    end

    assign full    = (count_reg == ols_pkg::COUNT_W'(CAP));
    assign ins_pos = (ols_pkg::COUNT_W'(pos_reg) > count_reg) ? count_reg
                                                             : ols_pkg::COUNT_W'(pos_reg);

    // Operation decode: target index and outcome
    always_comb begin
        ins_next = 1'b0;
        del_next = 1'b0;
        ok_next  = 1'b0;
        idx_next = '0;
        unique case (op_reg)
            ols_pkg::OP_APPEND: begin
                ins_next = !full;
                ok_next  = !full;
                idx_next = ols_pkg::IDX_W'(count_reg);
            end
            ols_pkg::OP_INS_FRONT: begin
                ins_next = !full;
                ok_next  = !full;
                idx_next = '0;
            end
            ols_pkg::OP_INS_POS: begin
                ins_next = !full;
                ok_next  = !full;
                idx_next = ols_pkg::IDX_W'(ins_pos);
            end
            ols_pkg::OP_REMOVE_VAL: begin
                del_next = found;
                ok_next  = found;
                idx_next = found_idx;
            end
            ols_pkg::OP_REMOVE_POS: begin
                del_next = (ols_pkg::COUNT_W'(pos_reg) < count_reg);
                ok_next  = del_next;
                idx_next = ols_pkg::IDX_W'(pos_reg);
            end
            ols_pkg::OP_QUERY: begin
                ok_next = 1'b1;
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ins_reg <= 1'b0;
            del_reg <= 1'b0;
            ok_reg  <= 1'b0;
        end else if (cmd.decide) begin
            ins_reg <= ins_next;
            del_reg <= del_next;
            ok_reg  <= ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            idx_reg <= idx_next;
        end
    end

    // Per-cell shift: up on insert, down on remove
    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++) begin : g_cell
            logic [ols_pkg::VAL_W-1:0] below;
            logic [ols_pkg::VAL_W-1:0] above;
            if (gi == 0) begin : g_first
                assign below = cell_reg[gi];
            end else begin : g_rest
                assign below = cell_reg[gi-1];
            end
            if (gi == CAP - 1) begin : g_last
                assign above = cell_reg[gi];
            end else begin : g_inner
                assign above = cell_reg[gi+1];
            end

            always_comb begin
                cell_next[gi] = cell_reg[gi];
                if (ins_reg) begin
                    if (ols_pkg::IDX_W'(gi) > idx_reg) begin
                        cell_next[gi] = below;
                    end else if (ols_pkg::IDX_W'(gi) == idx_reg) begin
                        cell_next[gi] = value_reg;
                    end
                end else if (del_reg) begin
                    if (ols_pkg::IDX_W'(gi) >= idx_reg) begin
                        cell_next[gi] = above;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (cmd.execute) begin
                    cell_reg[gi] <= cell_next[gi];
                end
            end
        end
    endgenerate

    // Entry count
    always_comb begin
        count_next = count_reg;
        if (ins_reg) begin
            count_next = count_reg + ols_pkg::COUNT_W'(1);
        end else if (del_reg) begin
            count_next = count_reg - ols_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.execute) begin
            count_reg <= count_next;
        end
    end

    // Tree leaves: live cells only, padding leaves never valid
    genvar gl;
    generate
        for (gl = 0; gl < LVS; gl++) begin : g_leaf
            if (gl < CAP) begin : g_used
                assign tval[LVS+gl] = cell_reg[gl];
                assign tvld[LVS+gl] = (ols_pkg::COUNT_W'(gl) < count_reg);
            end else begin : g_pad
                assign tval[LVS+gl] = '0;
                assign tvld[LVS+gl] = 1'b0;
            end
        end
        for (gl = 1; gl < LVS; gl++) begin : g_node
            assign tval[gl] = node_val_reg[gl];
            assign tvld[gl] = node_vld_reg[gl];
        end
    endgenerate
    assign tval[0] = '0;
    assign tvld[0] = 1'b0;

    // Free-running tree: each level settles in the cycle after its children
    always_ff @(posedge aclk) begin
        for (int n = 1; n < LVS; n++) begin
            if (tvld[2*n] && (!tvld[2*n+1] ||
                              $signed(tval[2*n]) >= $signed(tval[2*n+1]))) begin
                node_val_reg[n] <= tval[2*n];
            end else begin
                node_val_reg[n] <= tval[2*n+1];
            end
            node_vld_reg[n] <= tvld[2*n] || tvld[2*n+1];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            ok_out_reg      <= ok_reg;
            count_out_reg   <= count_reg;
            largest_out_reg <= node_vld_reg[1] ? node_val_reg[1] : '0;
        end
    end

    assign ok_out      = ok_out_reg;
    assign count_out   = count_out_reg;
    assign largest_out = largest_out_reg;

endmodule

[hw/rtl/ols_ctrl.sv]
// ols_ctrl: sequencer for the ordered list store. Drives the stream
// handshakes and the datapath commands. Depends on ols_pkg.
`timescale 1ns / 1ps

module ols_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ols_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FIND = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_MAX  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [ols_pkg::LVL_W-1:0] lvl_reg, lvl_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      out_free;

    // Result slot can take a new item when empty or being drained
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_item = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND: begin
                cmd.decide = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                lvl_next    = ols_pkg::LVL_W'(ols_pkg::LEVELS - 1);
                state_next  = ST_MAX;
            end
            ST_MAX: begin
                // wait for the max tree to ripple up one level per cycle
                lvl_next = lvl_reg - ols_pkg::LVL_W'(1);
                if (lvl_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.load_out = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lvl_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lvl_reg     <= lvl_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

[hw/rtl/ordered_list_store.sv]
// ordered_list_store: top level, stream ports around controller and
// datapath. Depends on ols_pkg, ols_ctrl, ols_datapath.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit entries. Each input item
// carries one operation and returns exactly one result item with the
// success flag, the count after the operation and the largest entry
// (0 when empty). Items are handled one at a time: after the accept,
// decode and match search, then the shift update, then the registered
// max tree climbs one level per cycle and the result is registered; the
// result load waits while the result slot stays full, and the next item
// can be taken in the cycle after the result is loaded. The result sits
// in an output register while the next item is accepted. Entry contents
// are not cleared by reset; only the count is.

module ordered_list_store (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] value, [36:32] position, rest zero
    input  logic [ols_pkg::S_DATA_W-1:0]     s_tdata,
    // [2:0] operation
    input  logic [ols_pkg::S_USER_W-1:0]     s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [4:0] count, [36:5] largest, rest zero
    output logic [ols_pkg::M_DATA_W-1:0]     m_tdata,
    // [0] ok
    output logic [ols_pkg::M_USER_W-1:0]     m_tuser
);

    ols_pkg::dp_cmd_t             cmd;
    logic                         ok_out;
    logic [ols_pkg::COUNT_W-1:0]  count_out;
    logic [ols_pkg::VAL_W-1:0]    largest_out;

    ols_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ols_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .op_in       (s_tuser[ols_pkg::OP_W-1:0]),
        .value_in    (s_tdata[ols_pkg::VAL_W-1:0]),
        .position_in (s_tdata[ols_pkg::VAL_W +: ols_pkg::POS_W]),
        .ok_out      (ok_out),
        .count_out   (count_out),
        .largest_out (largest_out)
    );

    // Pack the result item
    assign m_tdata = ols_pkg::M_DATA_W'({largest_out, count_out});
    assign m_tuser = ok_out;

endmodule

[hw/rtl/ols_checker.sv]
// ols_checker: port-level checks on ordered_list_store, bound to the top.
// Depends on ols_pkg and ordered_list_store.
`timescale 1ns / 1ps

module ols_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [ols_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic [ols_pkg::M_USER_W-1:0]     m_tuser
);

    // One item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ols: item accepted while previous still in work");

    // Stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("ols: result changed while stalled");

    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[ols_pkg::COUNT_W-1:0] <=
                      ols_pkg::COUNT_W'(ols_pkg::CAPACITY)))
        else $error("ols: count above capacity");

    // Empty store reports zero as largest
    a_empty_largest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[ols_pkg::COUNT_W-1:0] == '0)) |->
            (m_tdata[ols_pkg::COUNT_W +: ols_pkg::VAL_W] == '0))
        else $error("ols: nonzero largest on empty store");

endmodule

bind ordered_list_store ols_checker u_ols_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/sv/tb.sv]
// tb: self-checking bench for ordered_list_store, with an in-bench list model
// that predicts every result item. Depends on ols_pkg and the ordered_list_store RTL.
`timescale 1ns / 1ps

module tb;

    // Operation codes the block does not define; both must fail
    localparam logic [ols_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [ols_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic                             ok;
        logic [ols_pkg::COUNT_W-1:0]      count;
        logic signed [ols_pkg::VAL_W-1:0] largest;
    } list_result_t;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [ols_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [ols_pkg::S_USER_W-1:0] s_tuser  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [ols_pkg::M_DATA_W-1:0] m_tdata;
    logic [ols_pkg::M_USER_W-1:0] m_tuser;

    // Shadow copy of the stored sequence and the results still to come
    logic signed [ols_pkg::VAL_W-1:0] list_model[$];
    list_result_t                     pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int full_hits       = 0;
    int failed_ops      = 0;
    int cycle_count     = 0;
    bit filling         = 1'b1;

    always #4 aclk = ~aclk;

    ordered_list_store dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Apply one operation to the shadow list and return the expected result
    function automatic list_result_t apply_list_op(
        logic [ols_pkg::OP_W-1:0]         op,
        logic signed [ols_pkg::VAL_W-1:0] value,
        logic [ols_pkg::POS_W-1:0]        pos);
        list_result_t                     res;
        logic signed [ols_pkg::VAL_W-1:0] top;
        int                               idx;
        bit                               room;
        res.ok = 1'b0;
        room   = list_model.size() < ols_pkg::CAPACITY;
        case (op)
            ols_pkg::OP_APPEND: begin
                if (room) begin
                    list_model.push_back(value);
                    res.ok = 1'b1;
                end
            end
            ols_pkg::OP_INS_FRONT: begin
                if (room) begin
                    list_model.push_front(value);
                    res.ok = 1'b1;
                end
            end
            ols_pkg::OP_INS_POS: begin
                // past the end means append
                if (room) begin
                    if (pos >= list_model.size())
                        list_model.push_back(value);
                    else
                        list_model.insert(pos, value);
                    res.ok = 1'b1;
                end
            end
            ols_pkg::OP_REMOVE_VAL: begin
                // only the first match goes
                idx = -1;
                foreach (list_model[i])
                    if (idx < 0 && list_model[i] == value)
                        idx = i;
                if (idx >= 0) begin
                    list_model.delete(idx);
                    res.ok = 1'b1;
                end
            end
            ols_pkg::OP_REMOVE_POS: begin
                if (pos < list_model.size()) begin
                    list_model.delete(pos);
                    res.ok = 1'b1;
                end
            end
            ols_pkg::OP_QUERY: res.ok = 1'b1;
            default:           res.ok = 1'b0;
        endcase
        top = '0;
        foreach (list_model[i])
            if (i == 0 || list_model[i] > top)
                top = list_model[i];
        res.count   = ols_pkg::COUNT_W'(list_model.size());
        res.largest = top;
        if (!res.ok)
            failed_ops++;
        if (list_model.size() == ols_pkg::CAPACITY)
            full_hits++;
        return res;
    endfunction

    function automatic logic signed [ols_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $urandom_range(6) - 3;
            3:       return -$urandom_range(1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    // Send one item; the prediction is made when the item is accepted
    task automatic send_op(logic [ols_pkg::OP_W-1:0] op,
                           logic signed [ols_pkg::VAL_W-1:0] value,
                           logic [ols_pkg::POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata                                   = '0;
        s_tdata[ols_pkg::VAL_W-1:0]               = value;
        s_tdata[ols_pkg::VAL_W +: ols_pkg::POS_W] = pos;
        s_tuser                                   = op;
        s_tvalid                                  = 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_results.push_back(apply_list_op(op, value, pos));
        items_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Random item: fill and drain swings so the full and empty states are reached
    task automatic send_random_item();
        logic [ols_pkg::OP_W-1:0]         op;
        logic signed [ols_pkg::VAL_W-1:0] value;
        logic [ols_pkg::POS_W-1:0]        pos;
        int                               r;
        int                               ins_pct;
        if (list_model.size() >= ols_pkg::CAPACITY)
            filling = 1'b0;
        else if (list_model.size() == 0)
            filling = 1'b1;
        else if ($urandom_range(49) == 0)
            filling = !filling;
        ins_pct = filling ? 75 : 30;
        r = $urandom_range(99);
        if (r < 3)
            op = r[0] ? OP_SPARE_6 : OP_SPARE_7;
        else if (r < 8)
            op = ols_pkg::OP_QUERY;
        else if (r < 8 + ins_pct) begin
            case ($urandom_range(2))
                0:       op = ols_pkg::OP_APPEND;
                1:       op = ols_pkg::OP_INS_FRONT;
                default: op = ols_pkg::OP_INS_POS;
            endcase
        end else
            op = $urandom_range(1) ? ols_pkg::OP_REMOVE_VAL : ols_pkg::OP_REMOVE_POS;
        // removes by value mostly hit a stored entry
        if (op == ols_pkg::OP_REMOVE_VAL && list_model.size() > 0 &&
            $urandom_range(3) != 0)
            value = list_model[$urandom_range(list_model.size() - 1)];
        else
            value = pick_value();
        if ($urandom_range(4) != 0)
            pos = ols_pkg::POS_W'($urandom_range(list_model.size()));
        else
            pos = ols_pkg::POS_W'($urandom_range(ols_pkg::CAPACITY));
        send_op(op, value, pos);
    endtask

    task automatic wait_results_done();
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    // Empty-store cases, extremes, duplicates, bad positions, spare codes
    task automatic test_directed_edges();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_op(ols_pkg::OP_QUERY, 0, 0);
        send_op(ols_pkg::OP_REMOVE_POS, 0, 0);
        send_op(ols_pkg::OP_REMOVE_VAL, 0, 0);
        send_op(ols_pkg::OP_APPEND, 32'sh7FFF_FFFF, 0);
        send_op(ols_pkg::OP_APPEND, 32'sh8000_0000, 0);
        send_op(ols_pkg::OP_INS_FRONT, -1, 0);
        send_op(ols_pkg::OP_INS_POS, 5, ols_pkg::POS_W'(ols_pkg::CAPACITY));
        send_op(ols_pkg::OP_INS_POS, 5, 1);
        send_op(ols_pkg::OP_REMOVE_VAL, 5, 0);
        send_op(ols_pkg::OP_REMOVE_VAL, 1234, 0);
        send_op(ols_pkg::OP_REMOVE_POS, 0, ols_pkg::POS_W'(ols_pkg::CAPACITY));
        send_op(ols_pkg::OP_REMOVE_POS, 0, 0);
        send_op(OP_SPARE_6, 7, 3);
        send_op(OP_SPARE_7, 7, 3);
    endtask

    // Fill to capacity, then every insert must fail; two removes at the last position follow
    task automatic test_full_store();
        int n;
        n = 0;
        while (list_model.size() < ols_pkg::CAPACITY) begin
            case (n % 3)
                0:       send_op(ols_pkg::OP_APPEND, pick_value(), 0);
                1:       send_op(ols_pkg::OP_INS_FRONT, pick_value(), 0);
                default: send_op(ols_pkg::OP_INS_POS, pick_value(),
                                 ols_pkg::POS_W'($urandom_range(list_model.size())));
            endcase
            n++;
        end
        send_op(ols_pkg::OP_APPEND, 1, 0);
        send_op(ols_pkg::OP_INS_FRONT, 2, 0);
        send_op(ols_pkg::OP_INS_POS, 3, 0);
        send_op(ols_pkg::OP_REMOVE_POS, 0, ols_pkg::POS_W'(ols_pkg::CAPACITY - 1));
        send_op(ols_pkg::OP_REMOVE_POS, 0, ols_pkg::POS_W'(ols_pkg::CAPACITY - 1));
    endtask

    task automatic test_random_traffic(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n)
            send_random_item();
    endtask

    // Receiver holds off long enough that the block stalls its input
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_seq++;
        repeat (40)
            send_random_item();
    endtask

    // Sender stops until every result is back, then resumes
    task automatic test_sender_pause();
        send_idle_pct = 10;
        recv_idle_pct = 30;
        wait_results_done();
        repeat (30)
            send_random_item();
    endtask

    // Receiver ready: random, or held low for a long stretch on request
    always @(negedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else
            m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each accepted result item with the oldest prediction
    always @(posedge aclk) begin : check_results
        list_result_t                     want;
        logic                             got_ok;
        logic [ols_pkg::COUNT_W-1:0]      got_count;
        logic signed [ols_pkg::VAL_W-1:0] got_largest;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            got_ok      = m_tuser[0];
            got_count   = m_tdata[ols_pkg::COUNT_W-1:0];
            got_largest = m_tdata[ols_pkg::COUNT_W +: ols_pkg::VAL_W];
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected result: ok %0b count %0d largest %0d",
                                       got_ok, got_count, got_largest));
            else begin
                want = pending_results.pop_front();
                if (got_ok !== want.ok)
                    note_failure($sformatf("result %0d ok: expected %0b, got %0b",
                                           results_checked, want.ok, got_ok));
                if (got_count !== want.count)
                    note_failure($sformatf("result %0d count: expected %0d, got %0d",
                                           results_checked, want.count, got_count));
                if (got_largest !== want.largest)
                    note_failure($sformatf("result %0d largest: expected %0d, got %0d",
                                           results_checked, want.largest, got_largest));
            end
        end
    end

    // Run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        test_directed_edges();
        test_full_store();
        test_random_traffic(520, 28, 67);
        test_random_traffic(520, 67, 28);
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic(520, 0, 0);

        recv_idle_pct = 0;
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d items through insert, remove, query and spare codes",
                 items_sent);
        $display("checked %0d results: %0d at full capacity, %0d failed operations",
                 results_checked, full_hits, failed_ops);
        if (mismatch_count == 0)
            $display("status: pass");
        else begin
            $display("%0d mismatches", mismatch_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/ols_pkg.sv
hw/rtl/ols_datapath.sv
hw/rtl/ols_ctrl.sv
hw/rtl/ordered_list_store.sv
hw/rtl/ols_checker.sv
tb/sv/tb.sv
